[sv/grid_word_search_8dir_macros.svh]
// Assertion macros for the word search block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef GRID_WORD_SEARCH_8DIR_MACROS_SVH
`define GRID_WORD_SEARCH_8DIR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/gws_pkg.sv]
// Shared types, codes and helper functions of the word search block.
// No dependencies; used by gws_search and the top level.
`timescale 1ns / 1ps

package gws_pkg;

	localparam int MAX_ROWS_DEF = 64;
	localparam int MAX_COLS_DEF = 64;
	localparam int MAX_WORD_DEF = 32;

	localparam logic [6:0] GRID_ROWS_RST = 7'd64;
	localparam logic [6:0] GRID_COLS_RST = 7'd64;

	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	typedef enum logic [1:0] {
		FUNC_CELL   = 2'd0,
		FUNC_WORD   = 2'd1,
		FUNC_SEARCH = 2'd2
	} func_t;

	typedef enum logic [2:0] {
		DIR_LEFT      = 3'd0,
		DIR_UPLEFT    = 3'd1,
		DIR_DOWNLEFT  = 3'd2,
		DIR_RIGHT     = 3'd3,
		DIR_UPRIGHT   = 3'd4,
		DIR_DOWNRIGHT = 3'd5,
		DIR_UP        = 3'd6,
		DIR_DOWN      = 3'd7
	} dir_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_LOAD0,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DIR,
		S_WALK_RD,
		S_WALK_CMP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] func;
		logic [5:0] cell_row;
		logic [5:0] cell_col;
		logic [7:0] letter;
		logic [4:0] word_pos;
		logic [5:0] word_len;
	} in_item_t;

	typedef struct packed {
		logic       found;
		logic [5:0] hit_row;
		logic [5:0] hit_col;
		logic [2:0] direction;
	} out_item_t;

	typedef struct packed {
		logic       start;
		logic       take;
		logic [5:0] len;
		logic [6:0] rows;
		logic [6:0] cols;
	} srch_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} srch_stat_t;

	function automatic logic dir_fits(dir_t d, logic left, logic right, logic up, logic down);
		logic ok;
		unique case (d)
			DIR_LEFT:      ok = left;
			DIR_UPLEFT:    ok = left & up;
			DIR_DOWNLEFT:  ok = left & down;
			DIR_RIGHT:     ok = right;
			DIR_UPRIGHT:   ok = right & up;
			DIR_DOWNRIGHT: ok = right & down;
			DIR_UP:        ok = up;
			DIR_DOWN:      ok = down;
			default:       ok = 1'b0;
		endcase
		return ok;
	endfunction

	// Linear address step for one letter along a direction.
	function automatic int dir_offset(dir_t d, int cols);
		int off;
		unique case (d)
			DIR_LEFT:      off = -1;
			DIR_UPLEFT:    off = -cols - 1;
			DIR_DOWNLEFT:  off = cols - 1;
			DIR_RIGHT:     off = 1;
			DIR_UPRIGHT:   off = -cols + 1;
			DIR_DOWNRIGHT: off = cols + 1;
			DIR_UP:        off = -cols;
			DIR_DOWN:      off = cols;
			default:       off = 0;
		endcase
		return off;
	endfunction

endpackage

[sv/gws_ram.sv]
// Synchronous single-port-write, single-port-read memory with registered read data.
// No dependencies; instantiated for the grid store and the word store.
`timescale 1ns / 1ps

module gws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/gws_search.sv]
// Search sequencer: walks the grid, tries each direction and compares letters.
// Depends on gws_pkg; reads the grid and word memories held by the top level.
`timescale 1ns / 1ps

module gws_search
	import gws_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_WORD = MAX_WORD_DEF,
	localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1,
	localparam int WAW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  srch_req_t       req,
	output srch_stat_t      stat,
	output out_item_t       res,
	output logic [AW-1:0]   grid_raddr,
	input  logic [7:0]      grid_rdata,
	output logic [WAW-1:0]  word_raddr,
	input  logic [7:0]      word_rdata
);

	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);
	localparam int LW  = $clog2(MAX_WORD + 1);

	state_t         state_q, state_d;
	logic [RCW-1:0] rows_q, rows_d, rows_cl;
	logic [CCW-1:0] cols_q, cols_d, cols_cl;
	logic [LW-1:0]  len_q, len_d, len_cl;
	logic [RIW-1:0] r_q, r_d;
	logic [CIW-1:0] c_q, c_d;
	logic [AW-1:0]  cell_addr_q, cell_addr_d;
	logic [AW-1:0]  row_base_q, row_base_d;
	logic [AW-1:0]  walk_addr_q, walk_addr_d;
	logic [AW-1:0]  off;
	logic [WAW-1:0] k_q, k_d;
	dir_t           dir_q, dir_d;
	logic [7:0]     word0_q, word0_d;
	logic           found_q, found_d;
	logic           fit_left, fit_right, fit_up, fit_down;
	logic           last_col, last_row;
	logic           adv_dir, adv_cell;

	always_comb begin
		if (req.rows == '0) begin
			rows_cl = RCW'(1);
		end else if (int'(req.rows) > MAX_ROWS) begin
			rows_cl = RCW'(MAX_ROWS);
		end else begin
			rows_cl = RCW'(req.rows);
		end
		if (req.cols == '0) begin
			cols_cl = CCW'(1);
		end else if (int'(req.cols) > MAX_COLS) begin
			cols_cl = CCW'(MAX_COLS);
		end else begin
			cols_cl = CCW'(req.cols);
		end
		if (int'(req.len) > MAX_WORD) begin
			len_cl = LW'(MAX_WORD);
		end else begin
			len_cl = LW'(req.len);
		end
	end

	assign fit_left  = (int'(c_q) + 1 >= int'(len_q));
	assign fit_right = (int'(cols_q) - int'(c_q) >= int'(len_q));
	assign fit_up    = (int'(r_q) + 1 >= int'(len_q));
	assign fit_down  = (int'(rows_q) - int'(r_q) >= int'(len_q));
	assign last_col  = (int'(c_q) + 1 == int'(cols_q));
	assign last_row  = (int'(r_q) + 1 == int'(rows_q));
	assign off       = AW'(dir_offset(dir_q, MAX_COLS));

	assign grid_raddr = (state_q == S_WALK_RD) ? walk_addr_q : cell_addr_q;
	assign word_raddr = (state_q == S_WALK_RD) ? k_q : '0;

	always_comb begin
		state_d     = state_q;
		rows_d      = rows_q;
		cols_d      = cols_q;
		len_d       = len_q;
		r_d         = r_q;
		c_d         = c_q;
		cell_addr_d = cell_addr_q;
		row_base_d  = row_base_q;
		walk_addr_d = walk_addr_q;
		k_d         = k_q;
		dir_d       = dir_q;
		word0_d     = word0_q;
		found_d     = found_q;
		adv_dir     = 1'b0;
		adv_cell    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (req.start) begin
					rows_d      = rows_cl;
					cols_d      = cols_cl;
					len_d       = len_cl;
					r_d         = '0;
					c_d         = '0;
					cell_addr_d = '0;
					row_base_d  = '0;
					dir_d       = DIR_LEFT;
					found_d     = 1'b0;
					state_d     = (req.len == '0) ? S_DONE : S_INIT;
				end
			end
			S_INIT: begin
				state_d = S_LOAD0;
			end
			S_LOAD0: begin
				word0_d = word_rdata;
				state_d = S_SCAN_CMP;
			end
			S_SCAN_RD: begin
				state_d = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (grid_rdata == word0_q) begin
					dir_d   = DIR_LEFT;
					state_d = S_DIR;
				end else begin
					adv_cell = 1'b1;
				end
			end
			S_DIR: begin
				if (dir_fits(dir_q, fit_left, fit_right, fit_up, fit_down)) begin
					if (len_q == LW'(1)) begin
						found_d = 1'b1;
						state_d = S_DONE;
					end else begin
						walk_addr_d = cell_addr_q + off;
						k_d         = WAW'(1);
						state_d     = S_WALK_RD;
					end
				end else begin
					adv_dir = 1'b1;
				end
			end
			S_WALK_RD: begin
				state_d = S_WALK_CMP;
			end
			S_WALK_CMP: begin
				if (grid_rdata == word_rdata) begin
					if (int'(k_q) + 1 == int'(len_q)) begin
						found_d = 1'b1;
						state_d = S_DONE;
					end else begin
						k_d         = k_q + WAW'(1);
						walk_addr_d = walk_addr_q + off;
						state_d     = S_WALK_RD;
					end
				end else begin
					adv_dir = 1'b1;
				end
			end
			S_DONE: begin
				if (req.take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (adv_dir) begin
			if (dir_q == DIR_DOWN) begin
				adv_cell = 1'b1;
			end else begin
				dir_d   = dir_t'(dir_q + 3'd1);
				state_d = S_DIR;
			end
		end

		if (adv_cell) begin
			if (last_col) begin
				if (last_row) begin
					state_d = S_DONE;
				end else begin
					r_d         = r_q + RIW'(1);
					c_d         = '0;
					row_base_d  = row_base_q + AW'(MAX_COLS);
					cell_addr_d = row_base_q + AW'(MAX_COLS);
					state_d     = S_SCAN_RD;
				end
			end else begin
				c_d         = c_q + CIW'(1);
				cell_addr_d = cell_addr_q + AW'(1);
				state_d     = S_SCAN_RD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		rows_q      <= rows_d;
		cols_q      <= cols_d;
		len_q       <= len_d;
		r_q         <= r_d;
		c_q         <= c_d;
		cell_addr_q <= cell_addr_d;
		row_base_q  <= row_base_d;
		walk_addr_q <= walk_addr_d;
		k_q         <= k_d;
		dir_q       <= dir_d;
		word0_q     <= word0_d;
		found_q     <= found_d;
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);

	assign res.found     = found_q;
	assign res.hit_row   = found_q ? 6'(r_q) : '0;
	assign res.hit_col   = found_q ? 6'(c_q) : '0;
	assign res.direction = found_q ? dir_q : DIR_LEFT;

endmodule

[sv/grid_word_search_8dir.sv]
// Top level of the word search block: register port, load path, memories, result register.
// Depends on gws_pkg, gws_ram, gws_search and grid_word_search_8dir_macros.svh.
//
// Use: items arrive on item/item_valid/item_stall. A cell write or a word letter write
// is taken whenever item_stall is low and gives no result; loads may follow back to
// back. A search item holds item_stall high until its single result has entered the
// result register. A search first reads the first word letter, then scans the grid
// cells row by row, comparing each with that letter. At a matching cell it tries the
// directions in order from left to down and compares the further letters along each;
// it stops at the first full match or after the last cell, then hands over the result.
// Every step waits on the registered read of the grid memory.
// Results leave on result/result_valid/result_stall from a register; a new item,
// including a search, is accepted while an earlier result waits there, and a finished
// search holds until that register is free. grid_rows and grid_cols sit at byte
// addresses 0 and 4; the user must write them only while the block is idle, as the
// block does not enforce it. Reset clears the control state and sets both dimensions
// to 64; the grid and word memories keep whatever they hold until written.
`timescale 1ns / 1ps

`include "grid_word_search_8dir_macros.svh"

module grid_word_search_8dir
	import gws_pkg::*;
#(
	parameter int MAX_ROWS = MAX_ROWS_DEF,
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_WORD = MAX_WORD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_stall,
	output out_item_t   result
);

	localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
	localparam int WAW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

	logic [6:0]     grid_rows_q;
	logic [6:0]     grid_cols_q;
	logic           cfg_we;
	logic           item_acc;
	logic           grid_we;
	logic           word_we;
	logic [AW-1:0]  grid_waddr;
	logic [AW-1:0]  grid_raddr;
	logic [7:0]     grid_rdata;
	logic [WAW-1:0] word_waddr;
	logic [WAW-1:0] word_raddr;
	logic [7:0]     word_rdata;
	srch_req_t      srch_req;
	srch_stat_t     srch_stat;
	out_item_t      srch_res;
	logic           result_valid_q;
	out_item_t      result_q;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_ROWS_RST;
			grid_cols_q <= GRID_COLS_RST;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_GRID_ROWS: grid_rows_q <= pwdata[6:0];
				REG_GRID_COLS: grid_cols_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_GRID_ROWS: prdata = {25'd0, grid_rows_q};
			REG_GRID_COLS: prdata = {25'd0, grid_cols_q};
			default:       prdata = '0;
		endcase
	end

	assign item_stall = srch_stat.busy;
	assign item_acc   = item_valid & ~item_stall;

	assign grid_we    = item_acc && (item.func == FUNC_CELL) &&
	                    (int'(item.cell_row) < MAX_ROWS) && (int'(item.cell_col) < MAX_COLS);
	assign grid_waddr = AW'(int'(item.cell_row) * MAX_COLS + int'(item.cell_col));
	assign word_we    = item_acc && (item.func == FUNC_WORD) && (int'(item.word_pos) < MAX_WORD);
	assign word_waddr = WAW'(item.word_pos);

	gws_ram #(
		.WIDTH (8),
		.DEPTH (MAX_ROWS * MAX_COLS)
	) u_grid_ram (
		.clk   (clk),
		.we    (grid_we),
		.waddr (grid_waddr),
		.wdata (item.letter),
		.raddr (grid_raddr),
		.rdata (grid_rdata)
	);

	gws_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WORD)
	) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_waddr),
		.wdata (item.letter),
		.raddr (word_raddr),
		.rdata (word_rdata)
	);

	assign srch_req.start = item_acc && (item.func == FUNC_SEARCH);
	assign srch_req.take  = srch_stat.done && (!result_valid_q || !result_stall);
	assign srch_req.len   = item.word_len;
	assign srch_req.rows  = grid_rows_q;
	assign srch_req.cols  = grid_cols_q;

	gws_search #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.MAX_WORD (MAX_WORD)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (srch_req),
		.stat       (srch_stat),
		.res        (srch_res),
		.grid_raddr (grid_raddr),
		.grid_rdata (grid_rdata),
		.word_raddr (word_raddr),
		.word_rdata (word_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (srch_req.take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (srch_req.take) begin
			result_q <= srch_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`GWS_ASSERT_NEXT(a_start_busy, srch_req.start, srch_stat.busy, "start did not set busy")
	`GWS_ASSERT_NEXT(a_take_idle, srch_req.take, !srch_stat.busy && result_valid_q, "bad handover")
	`GWS_ASSERT_NOW(a_rise_from_done, $rose(result_valid_q), $past(srch_stat.done), "early result")
	`GWS_ASSERT_NOW(a_no_write_busy, srch_stat.busy && !srch_req.take, !grid_we && !word_we, "busy write")

endmodule
